// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tune command parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/tcp_pkg.sv =====
// Types and constants of the tune command parser.
package tcp_pkg;

    localparam int MAX_NOTES = 16;
    localparam int NOTES_W = $clog2(MAX_NOTES + 1);
    localparam logic [NOTES_W-1:0] MAX_CNT = NOTES_W'(MAX_NOTES);

    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_END = 8'h00;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_LOW = 8'h31;
    localparam logic [7:0] DIGIT_HIGH = 8'h38;

    typedef enum logic [1:0] {
        PH_STOPPED,
        PH_LETTER,
        PH_MODDUR,
        PH_DUR
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NOTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MOD_NONE = 2'd0,
        MOD_CARET = 2'd1,
        MOD_HASH = 2'd2
    } mod_t;

    typedef enum logic [2:0] {
        ERR_UNRECOGNISED = 3'd0,
        ERR_TOO_MANY = 3'd1,
        ERR_BAD_LETTER = 3'd2,
        ERR_INCOMPLETE = 3'd3,
        ERR_BAD_MOD = 3'd4,
        ERR_BAD_DURATION = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_req;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] pitch_letter;
        mod_t       pitch_mod;
        logic [3:0] duration;
        logic [3:0] note_index;
        logic [4:0] note_count;
        logic [2:0] error_code;
    } result_t;

endpackage

// ===== rtl/tcp_in_if.sv =====
// Command character channel.
interface tcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_req;

    modport source (output valid, output char_code, output start_req, input ready);
    modport sink (input valid, input char_code, input start_req, output ready);
endinterface

// ===== rtl/tcp_out_if.sv =====
// Parse result channel.
interface tcp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] pitch_letter;
    logic [1:0] pitch_mod;
    logic [3:0] duration;
    logic [3:0] note_index;
    logic [4:0] note_count;
    logic [2:0] error_code;

    modport source (
        output valid, output kind, output pitch_letter, output pitch_mod,
        output duration, output note_index, output note_count, output error_code,
        input ready
    );
    modport sink (
        input valid, input kind, input pitch_letter, input pitch_mod,
        input duration, input note_index, input note_count, input error_code,
        output ready
    );
endinterface

// ===== rtl/tcp_in_stage.sv =====
// Input register that holds one command character word.
`include "assert_macros.svh"

module tcp_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    tcp_in_if.sink          cmd,
    input  logic            down_ready,
    output logic            item_valid,
    output tcp_pkg::item_t  item
);
    import tcp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  advance;
    logic  load;

    assign advance = valid_reg && down_ready;
    assign cmd.ready = !valid_reg || down_ready;
    assign load = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{char_code: cmd.char_code, start_req: cmd.start_req};
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

    `ASSERT_CLK(a_held_word, (valid_reg && !down_ready) |=> (valid_reg && $stable(item_reg)), "held input word changed")

endmodule

// ===== rtl/tcp_parse.sv =====
// Parser state and the decode of one character into at most one result.
`include "assert_macros.svh"

module tcp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  tcp_pkg::item_t    item,
    output logic              res_valid,
    output tcp_pkg::result_t  res
);
    import tcp_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [NOTES_W-1:0] notes_reg;
    logic [NOTES_W-1:0] notes_next;
    logic [2:0]         letter_reg;
    logic [2:0]         letter_next;
    mod_t               mod_reg;
    mod_t               mod_next;

    logic [7:0] c;
    logic       is_digit;
    logic       is_letter;
    logic       is_end;

    assign c = item.char_code;
    assign is_digit = (c >= DIGIT_LOW) && (c <= DIGIT_HIGH);
    assign is_letter = (c >= CHAR_A) && (c <= CHAR_G);
    assign is_end = (c == CHAR_END);

    always_comb
    begin
        phase_next = phase_reg;
        notes_next = notes_reg;
        letter_next = letter_reg;
        mod_next = mod_reg;
        res_valid = 1'b0;
        res = '0;
        if (item.start_req)
        begin
            notes_next = '0;
            letter_next = '0;
            mod_next = MOD_NONE;
            if (c == CHAR_T)
            begin
                phase_next = PH_LETTER;
            end
            else
            begin
                phase_next = PH_STOPPED;
                res_valid = 1'b1;
                res.kind = KIND_ERROR;
                res.error_code = ERR_UNRECOGNISED;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LETTER:
                begin
                    res_valid = 1'b1;
                    phase_next = PH_STOPPED;
                    if (is_end)
                    begin
                        res.kind = KIND_DONE;
                        res.note_count = 5'(notes_reg);
                    end
                    else if (notes_reg >= MAX_CNT)
                    begin
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_TOO_MANY;
                    end
                    else if (!is_letter)
                    begin
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_BAD_LETTER;
                    end
                    else
                    begin
                        res_valid = 1'b0;
                        letter_next = 3'(c - CHAR_A);
                        mod_next = MOD_NONE;
                        phase_next = PH_MODDUR;
                    end
                end
                PH_MODDUR, PH_DUR:
                begin
                    res_valid = 1'b1;
                    phase_next = PH_STOPPED;
                    if (phase_reg == PH_MODDUR && c == CHAR_CARET)
                    begin
                        res_valid = 1'b0;
                        mod_next = MOD_CARET;
                        phase_next = PH_DUR;
                    end
                    else if (phase_reg == PH_MODDUR && c == CHAR_HASH)
                    begin
                        res_valid = 1'b0;
                        mod_next = MOD_HASH;
                        phase_next = PH_DUR;
                    end
                    else if (is_digit)
                    begin
                        res.kind = KIND_NOTE;
                        res.pitch_letter = letter_reg;
                        res.pitch_mod = mod_reg;
                        res.duration = 4'(c - DIGIT_ZERO);
                        res.note_index = 4'(notes_reg);
                        notes_next = notes_reg + 1'b1;
                        phase_next = PH_LETTER;
                    end
                    else if (is_end)
                    begin
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_INCOMPLETE;
                    end
                    else
                    begin
                        res.kind = KIND_ERROR;
                        res.error_code = (phase_reg == PH_MODDUR) ? ERR_BAD_MOD
                                                                  : ERR_BAD_DURATION;
                    end
                end
                default:
                begin
                    phase_next = PH_STOPPED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STOPPED;
            notes_reg <= '0;
            letter_reg <= '0;
            mod_reg <= MOD_NONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            notes_reg <= notes_next;
            letter_reg <= letter_next;
            mod_reg <= mod_next;
        end
    end

    `ASSERT_NEVER(a_notes_bound, notes_reg > MAX_CNT, "note count passed its limit")
    `ASSERT_CLK(a_stop_after_result, (fire && res_valid && res.kind != KIND_NOTE) |=> (phase_reg == PH_STOPPED), "parser kept running after done or error")
    `ASSERT_CLK(a_note_duration, (fire && res_valid && res.kind == KIND_NOTE) |-> (res.duration >= 4'd1 && res.duration <= 4'd8), "note duration out of range")

endmodule

// ===== rtl/tcp_out_stage.sv =====
// Result register that drives the output channel.
module tcp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tcp_pkg::result_t  res_in,
    output logic              up_ready,
    tcp_out_if.source         res
);
    import tcp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign up_ready = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign res.valid = valid_reg;
    assign res.kind = data_reg.kind;
    assign res.pitch_letter = data_reg.pitch_letter;
    assign res.pitch_mod = data_reg.pitch_mod;
    assign res.duration = data_reg.duration;
    assign res.note_index = data_reg.note_index;
    assign res.note_count = data_reg.note_count;
    assign res.error_code = data_reg.error_code;

endmodule

// ===== rtl/tune_command_parser.sv =====
// Top level of the tune command parser.
//
//   Channel  Role    Word contents
//   cmd      sink    char_code, start_req
//   res      source  kind, pitch_letter, pitch_mod, duration, note_index,
//                    note_count, error_code
//
// One character word is taken each cycle while cmd.ready is high. A result is loaded into
// the result register when its character leaves the input register, and is offered on res.
// Reset is asynchronous and leaves the parser stopped, waiting for a start word.
// A stalled result holds the result register, which in turn holds the input
// register, so cmd.ready drops only while both registers are full and res.ready is low.
module tune_command_parser (
    input  logic      clk,
    input  logic      rst_n,
    tcp_in_if.sink    cmd,
    tcp_out_if.source res
);
    import tcp_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    out_ready;
    logic    fire;
    logic    res_valid;
    result_t result;

    assign fire = item_valid && out_ready;

    tcp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .down_ready (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    tcp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (result)
    );

    tcp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && res_valid),
        .res_in   (result),
        .up_ready (out_ready),
        .res      (res)
    );

endmodule
